// ===== src/rau_pkg.sv =====
// shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic [2:0] OP_SET = 3'd0;
   localparam logic [2:0] OP_ADD = 3'd1;
   localparam logic [2:0] OP_SUB = 3'd2;
   localparam logic [2:0] OP_MUL = 3'd3;
   localparam logic [2:0] OP_DIV = 3'd4;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] operand_numerator;
      logic [31:0] operand_denominator;
   } req_type;

   typedef struct packed {
      logic [31:0] result_numerator;
      logic [30:0] result_denominator;
      logic        overflow;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/rau_if.sv =====
// valid/ready channel interfaces for request and response beats
`default_nettype none
interface rau_req_if;
   logic              valid;
   logic              ready;
   rau_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rau_rsp_if;
   logic              valid;
   logic              ready;
   rau_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/rational_arithmetic_unit.sv =====
// Accumulating rational arithmetic unit (top level).
// Request channel req_ carries an operation (set, add, subtract, multiply,
// divide) and an operand fraction; the response channel rsp_ returns the
// reduced accumulator fraction and an overflow flag, one beat per request.
// The accumulator is combined with the operand by cross-multiplication on
// one shared multiplier (three products), then normalized: a zero term
// gives 0/1, otherwise the gcd is found by Euclid's algorithm on a single
// 64-bit restoring divider, and both terms are divided by it on the same
// divider; Euclid needs at most about 92 remainder steps for 64-bit terms.
// A zero term or an unused operation skips the divider. One request is
// worked at a time; req_ready is low meanwhile.
// A finished response waits in the output register while rsp_ready is low,
// and the next request is taken only after it is delivered.
// Reset (synchronous, active high) sets the accumulator to 0/1 and idles.
`default_nettype none
module rational_arithmetic_unit #(
   parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   rau_req_if.sink  req,
   rau_rsp_if.source rsp
);
   import rau_pkg::*;
   localparam int VW = VALUE_WIDTH;
   localparam logic [63:0] VHALF = 64'd1 << (VW - 1);

   localparam logic [3:0] S_IDLE = 4'd0, S_M0 = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
      S_M3 = 4'd4, S_M4 = 4'd5, S_COMB = 4'd6, S_GCD = 4'd7, S_GW = 4'd8,
      S_DN = 4'd9, S_DNW = 4'd10, S_DD = 4'd11, S_DDW = 4'd12, S_FIN = 4'd13,
      S_OUT = 4'd14;

   logic [3:0]  st_ff;
   logic [VW-1:0] accn_ff, accd_ff;
   logic [2:0]  op_ff;
   logic        on_neg_ff, od_neg_ff, an_neg_ff, ad_neg_ff;
   logic [31:0] on_mag_ff, od_mag_ff, an_mag_ff, ad_mag_ff;
   logic [63:0] p0_ff, p1_ff, p2_ff;   // products
   logic [63:0] mn_ff, md_ff, ga_ff, gb_ff;
   logic        neg_ff;
   rsp_type     out_ff;

   // sign/magnitude decode of a VW-bit field
   function automatic logic [32:0] dec(input logic [31:0] raw);
      logic [VW-1:0] v;
      logic [31:0]   m;
      v = raw[VW-1:0];
      m = v[VW-1] ? 32'(~v + VW'(1)) : 32'(v);
      if (v[VW-1] && m == 32'd0) m = 32'(VHALF);
      return {v[VW-1], m};
   endfunction

   // shared multiplier operand select
   logic [31:0] ma, mb;
   logic [63:0] prod;
   always_comb begin
      ma = an_mag_ff; mb = od_mag_ff;
      case (st_ff)
         S_M0: begin ma = an_mag_ff; mb = (op_ff == OP_MUL) ? on_mag_ff : od_mag_ff; end
         S_M1: begin ma = on_mag_ff; mb = ad_mag_ff; end
         S_M2: begin ma = ad_mag_ff; mb = (op_ff == OP_DIV) ? on_mag_ff : od_mag_ff; end
         default: begin ma = an_mag_ff; mb = od_mag_ff; end
      endcase
   end
   rau_mul #(.W(32)) u_mul (.clock(clock), .a(ma), .b(mb), .p(prod));

   // shared divider
   logic        dstart, ddone;
   logic [63:0] ddvd, ddvs, dq, dr;
   always_comb begin
      dstart = (st_ff == S_GCD) || (st_ff == S_DN) || (st_ff == S_DD);
      ddvd = ga_ff; ddvs = gb_ff;
      if (st_ff == S_DN) begin ddvd = mn_ff; ddvs = ga_ff; end
      if (st_ff == S_DD) begin ddvd = md_ff; ddvs = ga_ff; end
   end
   rau_div #(.W(64)) u_div (.clock(clock), .reset(reset), .start(dstart),
      .dividend(ddvd), .divisor(ddvs), .done(ddone), .quotient(dq), .remainder(dr));

   // signed combine of the two cross products for add and subtract
   logic        t_neg, a_neg, sum_neg;
   logic [63:0] sum_mag;
   always_comb begin
      a_neg = an_neg_ff ^ od_neg_ff;
      t_neg = (on_neg_ff ^ ad_neg_ff) ^ (op_ff == OP_SUB);
      if (a_neg == t_neg) begin
         sum_neg = a_neg; sum_mag = p0_ff + p1_ff;
      end else if (p0_ff >= p1_ff) begin
         sum_neg = a_neg; sum_mag = p0_ff - p1_ff;
      end else begin
         sum_neg = t_neg; sum_mag = p1_ff - p0_ff;
      end
   end

   // final wrap and overflow
   logic        ovf;
   logic [VW-1:0] rn;
   logic [VW-2:0] rd;
   always_comb begin
      ovf = (neg_ff ? (mn_ff > VHALF) : (mn_ff >= VHALF)) || (md_ff >= VHALF);
      rn = neg_ff ? VW'(64'd0 - mn_ff) : mn_ff[VW-1:0];
      rd = md_ff[VW-2:0];
      if (rd == '0 || rn == '0) rd = (VW-1)'(1);
   end

   logic [32:0] dn_on, dn_od, dn_an, dn_ad;
   assign dn_on = dec(req.data.operand_numerator);
   assign dn_od = dec(req.data.operand_denominator);
   assign dn_an = dec(32'(accn_ff));
   assign dn_ad = dec(32'(accd_ff));

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; accn_ff <= '0; accd_ff <= VW'(1);
      end else begin
         case (st_ff)
            S_IDLE: if (req.valid) begin
               op_ff <= req.data.operation;
               {on_neg_ff, on_mag_ff} <= dn_on;
               {od_neg_ff, od_mag_ff} <= dn_od;
               {an_neg_ff, an_mag_ff} <= dn_an;
               {ad_neg_ff, ad_mag_ff} <= dn_ad;
               st_ff <= S_M0;
            end
            S_M0: st_ff <= S_M1;
            S_M1: begin p0_ff <= prod; st_ff <= S_M2; end
            S_M2: begin p1_ff <= prod; st_ff <= S_M3; end
            S_M3: begin p2_ff <= prod; st_ff <= S_COMB; end
            S_COMB: begin
               // num/den selection per operation
               case (op_ff)
                  OP_SET: begin
                     mn_ff <= {32'd0, on_mag_ff}; md_ff <= {32'd0, od_mag_ff};
                     neg_ff <= on_neg_ff ^ od_neg_ff;
                  end
                  OP_ADD, OP_SUB: begin
                     mn_ff <= sum_mag; md_ff <= p2_ff;
                     neg_ff <= sum_neg ^ ad_neg_ff ^ od_neg_ff;
                  end
                  OP_MUL: begin
                     mn_ff <= p0_ff; md_ff <= p2_ff;
                     neg_ff <= an_neg_ff ^ on_neg_ff ^ ad_neg_ff ^ od_neg_ff;
                  end
                  OP_DIV: begin
                     mn_ff <= p0_ff; md_ff <= p2_ff;
                     neg_ff <= an_neg_ff ^ od_neg_ff ^ ad_neg_ff ^ on_neg_ff;
                  end
                  default: begin
                     mn_ff <= '0; md_ff <= '0; neg_ff <= 1'b0;
                  end
               endcase
               st_ff <= S_M4;
            end
            S_M4: begin
               if (op_ff > OP_DIV) begin
                  out_ff <= '{32'(signed'(accn_ff)), 31'(accd_ff), 1'b0};
                  st_ff <= S_OUT;
               end else if (mn_ff == '0 || md_ff == '0) begin
                  accn_ff <= '0; accd_ff <= VW'(1);
                  out_ff <= '{32'd0, 31'd1, 1'b0};
                  st_ff <= S_OUT;
               end else begin
                  ga_ff <= mn_ff; gb_ff <= md_ff; st_ff <= S_GCD;
               end
            end
            S_GCD: st_ff <= S_GW;
            S_GW: if (ddone) begin
               ga_ff <= gb_ff; gb_ff <= dr;
               st_ff <= (dr == '0) ? S_DN : S_GCD;
            end
            S_DN: st_ff <= S_DNW;
            S_DNW: if (ddone) begin mn_ff <= dq; st_ff <= S_DD; end
            S_DD: st_ff <= S_DDW;
            S_DDW: if (ddone) begin md_ff <= dq; st_ff <= S_FIN; end
            S_FIN: begin
               accn_ff <= rn; accd_ff <= {1'b0, rd};
               out_ff <= '{32'(signed'(rn)), 31'(rd), ovf};
               st_ff <= S_OUT;
            end
            S_OUT: if (rsp.ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = (st_ff == S_OUT);
   assign rsp.data  = out_ff;

   // response only while no request is taken
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && req.ready)) else $error("ready while response pending");
   // stored denominator never zero
   a_den: assert property (@(posedge clock) disable iff (reset)
      accd_ff != '0) else $error("zero denominator stored");
   // output denominator nonzero
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.data.result_denominator != 31'd0) else $error("bad rsp");
endmodule
`default_nettype wire

// ===== src/rau_mul.sv =====
// 32x32 unsigned multiplier with registered product, shared by the sequencer
`default_nettype none
module rau_mul #(
   parameter int W = 32
) (
   input  wire logic           clock,
   input  wire logic [W-1:0]   a,
   input  wire logic [W-1:0]   b,
   output logic [2*W-1:0]      p
);
   logic [2*W-1:0] p_ff;
   // registered product
   always_ff @(posedge clock) begin
      p_ff <= {{W{1'b0}}, a} * {{W{1'b0}}, b};
   end
   assign p = p_ff;
endmodule
`default_nettype wire

// ===== src/rau_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module rau_div #(
   parameter int W = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quotient,
   output logic [W-1:0]      remainder
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  q_ff, q_in, r_ff, r_in, d_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [W:0]    trial;

   // one shift-subtract step
   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[W-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; cnt_in = CW'(W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-2:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) d_ff <= divisor;
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire
